### hdl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the synchronous reset is low.
`define IUHC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define IUHC_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### hdl/iuhc_pkg.sv
// Types, constants and header offsets of the IPv4/UDP header checker.
`timescale 1ns / 1ps

package iuhc_pkg;

    // Width of the saturating byte counter.
    localparam int OFFSET_BITS = 16;
    // Width used when the counter is compared against 20 plus the UDP length.
    localparam int CMP_W = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 1;

    typedef logic [OFFSET_BITS-1:0] t_offset;

    localparam logic [7:0] FIRST_BYTE_OK = 8'h45;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IPIP = 8'd4;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        CLASS_OTHER = 3'd0,
        CLASS_UDP   = 3'd1,
        CLASS_ICMP  = 3'd2,
        CLASS_TCP   = 3'd3,
        CLASS_IPIP  = 3'd4
    } t_proto_class;

    // Byte offsets within the captured packet.
    localparam t_offset OFF_FIRST    = t_offset'(0);
    localparam t_offset OFF_LEN_HI   = t_offset'(2);
    localparam t_offset OFF_LEN_LO   = t_offset'(3);
    localparam t_offset OFF_PROTO    = t_offset'(9);
    localparam t_offset OFF_IPCS_HI  = t_offset'(10);
    localparam t_offset OFF_IPCS_LO  = t_offset'(11);
    localparam t_offset OFF_SRC      = t_offset'(12);
    localparam t_offset OFF_UDP      = t_offset'(20);
    localparam t_offset OFF_UDPCS_HI = t_offset'(26);
    localparam t_offset OFF_UDPCS_LO = t_offset'(27);
    localparam t_offset OFF_PAYLOAD  = t_offset'(28);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic         decoded;
        logic [7:0]   protocol;
        t_proto_class protocol_class;
        logic [15:0]  total_length;
        logic [31:0]  source_addr;
        logic [31:0]  dest_addr;
        logic         ip_checksum_ok;
        logic         udp_present;
        logic [15:0]  source_port;
        logic [15:0]  dest_port;
        logic [15:0]  udp_length;
        logic         udp_checksum_ok;
    } t_out_word;

    // Packet state frozen on the final byte, handed from accumulation to verdict.
    typedef struct packed {
        t_offset     count;
        logic [7:0]  first_byte;
        logic [7:0]  proto;
        logic [15:0] total_length;
        logic [63:0] addr;
        logic [15:0] ip_csum;
        logic [15:0] udp_csum;
        logic [47:0] port_len;
        logic [19:0] header_sum;
        logic [31:0] udp_sum;
    } t_snap;

endpackage

### hdl/iuhc_if.sv
// Valid/ready channel interfaces for the input bytes and the result words.
`timescale 1ns / 1ps

interface iuhc_in_if import iuhc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iuhc_out_if import iuhc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/iuhc_accum.sv
// Per-byte field capture and running checksum sums, with the end-of-packet snapshot.
`timescale 1ns / 1ps

module iuhc_accum import iuhc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_word,
    output logic     o_ready,
    output logic     o_snap_valid,
    output t_snap    o_snap,
    input  logic     i_snap_ready
);

    logic        r_snap_valid;
    t_snap       r_snap;

    t_offset     r_offset, n_offset;
    logic [19:0] r_header_sum, n_header_sum;
    logic [31:0] r_udp_sum, n_udp_sum;
    logic [7:0]  r_first_byte, n_first_byte;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_length, n_length;
    logic [63:0] r_addr, n_addr;
    logic [15:0] r_ip_csum, n_ip_csum;
    logic [15:0] r_udp_csum, n_udp_csum;
    logic [47:0] r_port_len, n_port_len;

    logic        accept;
    logic        active;
    logic [15:0] w;
    logic [CMP_W-1:0] off_x, udp_end;
    logic [7:0]  b;

    assign o_ready      = !r_snap_valid || i_snap_ready;
    assign accept       = i_valid && o_ready;
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    assign b       = i_word.data_byte;
    assign active  = ~&r_offset;
    assign w       = r_offset[0] ? {8'h00, b} : {b, 8'h00};
    assign off_x   = CMP_W'(r_offset);
    assign udp_end = CMP_W'(r_port_len[15:0]) + CMP_W'(OFF_UDP);

    always_comb begin
        n_offset     = r_offset;
        n_header_sum = r_header_sum;
        n_udp_sum    = r_udp_sum;
        n_first_byte = r_first_byte;
        n_proto      = r_proto;
        n_length     = r_length;
        n_addr       = r_addr;
        n_ip_csum    = r_ip_csum;
        n_udp_csum   = r_udp_csum;
        n_port_len   = r_port_len;
        if (active) begin
            n_offset = r_offset + t_offset'(1);
            if (r_offset == OFF_FIRST) begin
                n_first_byte = b;
            end
            if (r_offset == OFF_LEN_HI || r_offset == OFF_LEN_LO) begin
                n_length = {r_length[7:0], b};
            end
            if (r_offset == OFF_PROTO) begin
                n_proto = b;
            end
            if (r_offset == OFF_IPCS_HI || r_offset == OFF_IPCS_LO) begin
                n_ip_csum = {r_ip_csum[7:0], b};
            end
            if (r_offset < OFF_UDP && r_offset != OFF_IPCS_HI && r_offset != OFF_IPCS_LO) begin
                n_header_sum = r_header_sum + 20'(w);
            end
            if (r_offset >= OFF_SRC && r_offset < OFF_UDP) begin
                n_addr    = {r_addr[55:0], b};
                n_udp_sum = r_udp_sum + 32'(w);
            end
            if (r_offset >= OFF_UDP && r_offset < OFF_UDPCS_HI) begin
                n_port_len = {r_port_len[39:0], b};
            end
            if (r_offset == OFF_UDPCS_HI || r_offset == OFF_UDPCS_LO) begin
                n_udp_csum = {r_udp_csum[7:0], b};
            end
            // Payload words past the UDP header, only as far as the UDP length reaches.
            if (r_offset >= OFF_PAYLOAD && off_x < udp_end) begin
                n_udp_sum = r_udp_sum + 32'(w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_word.last_byte)) begin
            r_offset     <= '0;
            r_header_sum <= '0;
            r_udp_sum    <= '0;
            r_first_byte <= '0;
            r_proto      <= '0;
            r_length     <= '0;
            r_addr       <= '0;
            r_ip_csum    <= '0;
            r_udp_csum   <= '0;
            r_port_len   <= '0;
        end else if (accept) begin
            r_offset     <= n_offset;
            r_header_sum <= n_header_sum;
            r_udp_sum    <= n_udp_sum;
            r_first_byte <= n_first_byte;
            r_proto      <= n_proto;
            r_length     <= n_length;
            r_addr       <= n_addr;
            r_ip_csum    <= n_ip_csum;
            r_udp_csum   <= n_udp_csum;
            r_port_len   <= n_port_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (accept && i_word.last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_ready) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_word.last_byte) begin
            r_snap.count        <= n_offset;
            r_snap.first_byte   <= n_first_byte;
            r_snap.proto        <= n_proto;
            r_snap.total_length <= n_length;
            r_snap.addr         <= n_addr;
            r_snap.ip_csum      <= n_ip_csum;
            r_snap.udp_csum     <= n_udp_csum;
            r_snap.port_len     <= n_port_len;
            r_snap.header_sum   <= n_header_sum;
            r_snap.udp_sum      <= n_udp_sum;
        end
    end

endmodule

### hdl/iuhc_verdict.sv
// Decode of the frozen packet state and the two checksum verdicts, over two stages.
`timescale 1ns / 1ps

module iuhc_verdict import iuhc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_snap_valid,
    input  t_snap     i_snap,
    output logic      o_snap_ready,
    output logic      o_valid,
    output t_out_word o_word,
    input  logic      i_ready
);

    // Header words that a short UDP length covers only in part.
    function automatic logic [15:0] covered_word(input logic [15:0] word,
                                                 input logic [15:0] ulen,
                                                 input logic [15:0] full_len);
        logic [15:0] res;
        res = 16'h0000;
        if (ulen >= full_len) begin
            res = word;
        end else if (ulen == full_len - 16'd1) begin
            res = {word[15:8], 8'h00};
        end
        return res;
    endfunction

    logic        r_mid_valid;
    t_out_word   r_mid_word;
    logic [31:0] r_mid_sum;
    logic        r_mid_len_ok;
    logic [15:0] r_mid_csum;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        out_free;
    logic        mid_load;
    t_out_word   n_mid_word;
    logic [31:0] n_mid_sum;
    logic        n_mid_len_ok;
    logic        dec, udp;
    t_proto_class cls;
    logic [15:0] sport, dport, ulen;
    logic [16:0] hf1, uf1;
    logic [15:0] hf2, uf2;
    t_out_word   n_out_word;

    assign out_free     = !r_out_valid || i_ready;
    assign o_snap_ready = !r_mid_valid || out_free;
    assign mid_load     = i_snap_valid && o_snap_ready;
    assign o_valid      = r_out_valid;
    assign o_word       = r_out_word;

    assign sport = i_snap.port_len[47:32];
    assign dport = i_snap.port_len[31:16];
    assign ulen  = i_snap.port_len[15:0];

    always_comb begin
        dec = (i_snap.count >= OFF_UDP) && (i_snap.first_byte == FIRST_BYTE_OK);
        udp = dec && (i_snap.proto == PROTO_UDP) && (i_snap.count >= OFF_PAYLOAD);
        case (i_snap.proto)
            PROTO_UDP:  cls = CLASS_UDP;
            PROTO_ICMP: cls = CLASS_ICMP;
            PROTO_TCP:  cls = CLASS_TCP;
            PROTO_IPIP: cls = CLASS_IPIP;
            default:    cls = CLASS_OTHER;
        endcase
        // The header sum is at most nine words, so two folds settle it.
        hf1 = 17'(i_snap.header_sum[15:0]) + 17'(i_snap.header_sum[19:16]);
        hf2 = hf1[15:0] + 16'(hf1[16]);

        n_mid_sum = i_snap.udp_sum + 32'(ulen) + 32'(PROTO_UDP)
                  + 32'(covered_word(sport, ulen, 16'd2))
                  + 32'(covered_word(dport, ulen, 16'd4))
                  + 32'(covered_word(ulen, ulen, 16'd6));
        n_mid_len_ok = CMP_W'(i_snap.count) >= (CMP_W'(ulen) + CMP_W'(OFF_UDP));

        n_mid_word = '0;
        if (dec) begin
            n_mid_word.decoded        = 1'b1;
            n_mid_word.protocol       = i_snap.proto;
            n_mid_word.protocol_class = cls;
            n_mid_word.total_length   = i_snap.total_length;
            n_mid_word.source_addr    = i_snap.addr[63:32];
            n_mid_word.dest_addr      = i_snap.addr[31:0];
            n_mid_word.ip_checksum_ok = (i_snap.ip_csum == ~hf2);
            if (udp) begin
                n_mid_word.udp_present = 1'b1;
                n_mid_word.source_port = sport;
                n_mid_word.dest_port   = dport;
                n_mid_word.udp_length  = ulen;
            end
        end
    end

    always_comb begin
        uf1 = 17'(r_mid_sum[15:0]) + 17'(r_mid_sum[31:16]);
        uf2 = uf1[15:0] + 16'(uf1[16]);
        n_out_word = r_mid_word;
        n_out_word.udp_checksum_ok = r_mid_word.udp_present && r_mid_len_ok
                                   && (r_mid_csum == ~uf2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_snap_ready) begin
                r_mid_valid <= i_snap_valid;
            end
            if (out_free) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_load) begin
            r_mid_word   <= n_mid_word;
            r_mid_sum    <= n_mid_sum;
            r_mid_len_ok <= n_mid_len_ok;
            r_mid_csum   <= i_snap.udp_csum;
        end
        if (out_free && r_mid_valid) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

### hdl/ipv4_udp_header_checker.sv
// After the final byte is taken into the snapshot register, a result word passes the verdict and output registers.
// Throughput: one byte per cycle while the input is not stalled;
// a result per cycle is possible, down to one-byte packets, while the sink takes every word.
// The input stalls only when the snapshot, verdict and output registers are all full and the sink is not ready.
// Reset (synchronous, active low) clears the counters, sums, held fields and valid flags.
`timescale 1ns / 1ps

module ipv4_udp_header_checker import iuhc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iuhc_in_if.sink           i_in,
    iuhc_out_if.source        o_out
);

    // The accumulator sees every byte. It keeps a saturating byte count, picks
    // the header fields out by offset and keeps two running sums: the IPv4
    // header sum (checksum field skipped) and the UDP sum over both addresses
    // and the payload from byte 28 up to the end that the UDP length claims.
    // On the final byte it freezes the updated state in a snapshot register
    // and clears itself, so the next packet may start in the very next cycle if the snapshot is not stalled.
    logic  snap_valid;
    logic  snap_ready;
    t_snap snap;

    iuhc_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_word       (i_in.data),
        .o_ready      (i_in.ready),
        .o_snap_valid (snap_valid),
        .o_snap       (snap),
        .i_snap_ready (snap_ready)
    );

    // The verdict path first decodes the snapshot, folds the header sum and
    // adds the pseudo-header terms and the covered UDP header words; the
    // second stage folds the UDP sum and compares it against the stored
    // checksum. A missing payload byte (fewer bytes than the UDP length
    // claims) forces the UDP verdict low. The last stage is the output
    // register, which holds its word until the sink takes it.
    iuhc_verdict u_verdict (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_snap_ready (snap_ready),
        .o_valid      (o_out.valid),
        .o_word       (o_out.data),
        .i_ready      (o_out.ready)
    );

endmodule

### hdl/iuhc_checker.sv
// Port-level assertions on the result channel of the header checker, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iuhc_checker import iuhc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_word
);

    `IUHC_ASSERT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped while stalled")
    `IUHC_ASSERT(a_hold_word, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_word), "result word changed while stalled")
    `IUHC_ASSERT(a_undecoded_zero, i_clk, i_rst_n, i_out_valid && !i_out_word.decoded |-> i_out_word.protocol == 8'd0 && i_out_word.total_length == 16'd0 && i_out_word.source_addr == 32'd0 && i_out_word.dest_addr == 32'd0 && !i_out_word.ip_checksum_ok && !i_out_word.udp_present, "undecoded packet carries fields")
    `IUHC_ASSERT(a_udp_consistent, i_clk, i_rst_n, i_out_valid && i_out_word.udp_present |-> i_out_word.decoded && i_out_word.protocol == PROTO_UDP && i_out_word.protocol_class == CLASS_UDP, "UDP flag disagrees with protocol")
    `IUHC_ASSERT_NORST(a_reset_empty, i_clk, $past(!i_rst_n) |-> !i_out_valid, "result valid right after reset")

endmodule

bind ipv4_udp_header_checker iuhc_checker u_iuhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.data)
);
